>>> rtl/divide_64_by_32_unsigned_defines.svh
// Assertion macros shared by the divider RTL.
`ifndef DIVIDE_64_BY_32_UNSIGNED_DEFINES_SVH
`define DIVIDE_64_BY_32_UNSIGNED_DEFINES_SVH

// Same-cycle implication, off during reset.
`define DVD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("divider check failed");

// Next-cycle implication, off during reset.
`define DVD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("divider check failed");

`endif

>>> rtl/dvd_pkg.sv
// Types, constants and the restoring step of the 64-by-32 divider.
`default_nettype none

package dvd_pkg;

    localparam int DVD_WORD_W         = 32;
    localparam int DVD_BITS_PER_STAGE = 4;

    typedef logic [DVD_WORD_W-1:0] t_word;

    typedef struct packed {
        t_word rem;
        t_word lo;
        t_word div;
        logic  ovf;
    } t_dvd_work;

    function automatic t_dvd_work dvd_step(input t_dvd_work w);
        logic [DVD_WORD_W:0] part;
        logic                qbit;
        t_dvd_work           r;
        part  = {w.rem, w.lo[DVD_WORD_W-1]};
        qbit  = (part >= {1'b0, w.div});
        r     = w;
        r.lo  = {w.lo[DVD_WORD_W-2:0], qbit};
        r.rem = qbit ? DVD_WORD_W'(part - {1'b0, w.div}) : part[DVD_WORD_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/dvd_if.sv
// Request and response channel interfaces of the divider.
`default_nettype none

interface dvd_req_if import dvd_pkg::*; ();
    logic  valid;
    logic  ready;
    t_word dividend_high;
    t_word dividend_low;
    t_word divisor;

    modport source(output valid, dividend_high, dividend_low, divisor, input ready);
    modport sink(input valid, dividend_high, dividend_low, divisor, output ready);
endinterface

interface dvd_rsp_if import dvd_pkg::*; ();
    logic  valid;
    logic  ready;
    t_word quotient;
    t_word remainder;
    logic  overflow;

    modport source(output valid, quotient, remainder, overflow, input ready);
    modport sink(input valid, quotient, remainder, overflow, output ready);
endinterface

`default_nettype wire

>>> rtl/dvd_front.sv
// Entry stage: overflow check and setup of the partial remainder.
`default_nettype none

`include "divide_64_by_32_unsigned_defines.svh"

module dvd_front import dvd_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dvd_req_if.sink    i_req,
    output t_dvd_work  o_work,
    output logic       o_valid,
    input  wire logic  i_ready
);

    logic      r_valid;
    t_dvd_work r_work;
    t_dvd_work n_work;
    logic      n_ovf;

    assign i_req.ready = !r_valid || i_ready;

    always_comb begin
        n_ovf      = (i_req.dividend_high >= i_req.divisor);
        n_work.ovf = n_ovf;
        // force all-zero quotient and remainder on overflow
        n_work.rem = n_ovf ? '0 : i_req.dividend_high;
        n_work.lo  = n_ovf ? '0 : i_req.dividend_low;
        n_work.div = n_ovf ? '1 : i_req.divisor;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready) begin
            r_work <= n_work;
        end
    end

    assign o_work  = r_work;
    assign o_valid = r_valid;

    `DVD_ASSERT_NOW(a_bubble_takes, i_clk, i_rst_n, !r_valid, i_req.ready)
    `DVD_ASSERT_NOW(a_ovf_setup, i_clk, i_rst_n, r_valid && r_work.ovf,
        r_work.rem == '0 && r_work.lo == '0 && r_work.div == '1)

endmodule

`default_nettype wire

>>> rtl/dvd_stage.sv
// One pipeline stage of restoring division steps.
`default_nettype none

`include "divide_64_by_32_unsigned_defines.svh"

module dvd_stage import dvd_pkg::*; #(
    parameter int P_BITS = DVD_BITS_PER_STAGE
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_dvd_work  i_work,
    input  wire logic       i_valid,
    output logic            o_ready,
    output t_dvd_work       o_work,
    output logic            o_valid,
    input  wire logic       i_ready
);

    logic      r_valid;
    t_dvd_work r_work;
    t_dvd_work n_work;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_work = i_work;
        for (int i = 0; i < P_BITS; i++) begin
            n_work = dvd_step(n_work);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_work <= n_work;
        end
    end

    assign o_work  = r_work;
    assign o_valid = r_valid;

    `DVD_ASSERT_NOW(a_rem_below_div, i_clk, i_rst_n, r_valid, r_work.rem < r_work.div)
    `DVD_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, r_valid && !i_ready,
        r_valid && $stable(r_work))

endmodule

`default_nettype wire

>>> rtl/divide_64_by_32_unsigned.sv
// Top level of the pipelined 64-by-32 unsigned divider.
//
//   channel  dir  payload                                  handshake
//   i_req    in   dividend_high, dividend_low, divisor     valid / ready
//   o_rsp    out  quotient, remainder, overflow            valid / ready
//
// A request passes the entry register, then the chain of restoring steps, P_BITS_PER_STAGE per register stage.
// One request enters per cycle while the output side takes results.
// Reset clears only the stage valid bits; no state survives a request.
// A stall at o_rsp backs up stage by stage and fills bubbles before holding.
`default_nettype none

`include "divide_64_by_32_unsigned_defines.svh"

module divide_64_by_32_unsigned import dvd_pkg::*; #(
    parameter int P_BITS_PER_STAGE = DVD_BITS_PER_STAGE
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dvd_req_if.sink    i_req,
    dvd_rsp_if.source  o_rsp
);

    localparam int NSTG = DVD_WORD_W / P_BITS_PER_STAGE;

    t_dvd_work       w_work  [0:NSTG];
    logic [NSTG:0]   w_valid;
    logic [NSTG:0]   w_ready;

    dvd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_work  (w_work[0]),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0])
    );

    for (genvar g = 0; g < NSTG; g++) begin : g_stage
        dvd_stage #(
            .P_BITS (P_BITS_PER_STAGE)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_work  (w_work[g]),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .o_work  (w_work[g+1]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1])
        );
    end

    assign w_ready[NSTG] = o_rsp.ready;
    assign o_rsp.valid     = w_valid[NSTG];
    assign o_rsp.quotient  = w_work[NSTG].lo;
    assign o_rsp.remainder = w_work[NSTG].rem;
    assign o_rsp.overflow  = w_work[NSTG].ovf;

    `DVD_ASSERT_NOW(a_ovf_zero, i_clk, i_rst_n, o_rsp.valid && o_rsp.overflow,
        o_rsp.quotient == '0 && o_rsp.remainder == '0)

endmodule

`default_nettype wire

>>> test/divide_64_by_32_unsigned_checker.sv
// Response checker for the 64-by-32 unsigned divider: predicts and compares responses.
`timescale 1ns / 100ps

module divide_64_by_32_unsigned_checker import dvd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dvd_req_if        i_req,
    dvd_rsp_if        i_rsp,
    output int        o_error_count,
    output int        o_pending
);

    typedef struct packed {
        t_word quotient;
        t_word remainder;
        logic  overflow;
    } t_division;

    t_division pending_divisions[$];
    int        error_total = 0;

    function automatic t_division divide_words(input t_word hi, input t_word lo,
                                               input t_word dv);
        logic [63:0] numerator;
        logic [63:0] wide_divisor;
        logic [63:0] wide_quotient;
        logic [63:0] wide_remainder;
        t_division   res;
        res = '0;
        if (hi >= dv) begin
            res.overflow = 1'b1;
        end else begin
            numerator      = {hi, lo};
            wide_divisor   = {32'd0, dv};
            wide_quotient  = numerator / wide_divisor;
            wide_remainder = numerator % wide_divisor;
            res.quotient   = wide_quotient[31:0];
            res.remainder  = wide_remainder[31:0];
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_division want;
        if (i_rst_n) begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (pending_divisions.size() == 0) begin
                    $error({"response with no request outstanding: ",
                            "quotient %h remainder %h overflow %b"},
                           i_rsp.quotient, i_rsp.remainder, i_rsp.overflow);
                    error_total++;
                end else begin
                    want = pending_divisions.pop_front();
                    if (i_rsp.quotient !== want.quotient) begin
                        $error("quotient mismatch: expected %h, actual %h",
                               want.quotient, i_rsp.quotient);
                        error_total++;
                    end
                    if (i_rsp.remainder !== want.remainder) begin
                        $error("remainder mismatch: expected %h, actual %h",
                               want.remainder, i_rsp.remainder);
                        error_total++;
                    end
                    if (i_rsp.overflow !== want.overflow) begin
                        $error("overflow mismatch: expected %b, actual %b",
                               want.overflow, i_rsp.overflow);
                        error_total++;
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                pending_divisions.push_back(divide_words(i_req.dividend_high,
                                                         i_req.dividend_low,
                                                         i_req.divisor));
            end
        end
        o_error_count <= error_total;
        o_pending     <= pending_divisions.size();
    end

endmodule

>>> test/tb_divide_64_by_32_unsigned.sv
// Testbench top for the 64-by-32 unsigned divider: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps

module tb_divide_64_by_32_unsigned import dvd_pkg::*; ();

    localparam int CYCLE_LIMIT     = 400000;
    localparam int ITEMS_PER_PHASE = 470;
    localparam int SETTLE_CYCLES   = 24;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   error_count;
    int   pending_count;
    int   cycle_count = 0;
    int   send_gap_pct = 0;
    int   rsp_stall_pct = 0;

    dvd_req_if req_if ();
    dvd_rsp_if rsp_if ();

    divide_64_by_32_unsigned DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    divide_64_by_32_unsigned_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_if),
        .i_rsp         (rsp_if),
        .o_error_count (error_count),
        .o_pending     (pending_count)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_request(input t_word hi, input t_word lo, input t_word dv);
        if ($urandom_range(99) < send_gap_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_gap_pct) @(posedge i_clk);
        end
        req_if.valid         <= 1'b1;
        req_if.dividend_high <= hi;
        req_if.dividend_low  <= lo;
        req_if.divisor       <= dv;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    task automatic drain_requests();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_random_requests(input int count);
        int    sel;
        t_word hi;
        t_word lo;
        t_word dv;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(99);
            dv  = $urandom >> $urandom_range(31);
            lo  = $urandom;
            if (sel < 12) begin
                if (sel < 2) dv = '0;
                hi = dv + ($urandom >> $urandom_range(31));
                if (hi < dv) hi = dv;
                if (sel == 11) hi = dv;
            end else begin
                if (dv == '0) dv = 32'd1;
                if (sel < 20) hi = dv - 32'd1;
                else hi = $urandom % dv;
            end
            send_request(hi, lo, dv);
        end
    endtask

    initial begin
        req_if.valid         <= 1'b0;
        req_if.dividend_high <= '0;
        req_if.dividend_low  <= '0;
        req_if.divisor       <= '0;
        i_rst_n              <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_request(32'h0000_0000, 32'hffff_ffff, 32'h0000_0000);
        send_request(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_request(32'hffff_ffff, 32'h0000_0000, 32'h0000_0001);
        send_request(32'h0000_0007, 32'h0000_0000, 32'h0000_0007);
        send_request(32'hffff_fffe, 32'hffff_ffff, 32'hffff_ffff);
        send_request(32'hffff_fffe, 32'h0000_0000, 32'hffff_ffff);
        send_request(32'h0000_0000, 32'hffff_ffff, 32'h0000_0001);
        send_request(32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
        send_request(32'h0000_0000, 32'h0000_0123, 32'hffff_ffff);
        send_request(32'h0000_0006, 32'hffff_ffff, 32'h0000_0007);
        send_request(32'h0000_0000, 32'h0000_0007, 32'h0000_0007);
        send_request(32'h7fff_ffff, 32'hffff_ffff, 32'h8000_0000);
        send_request(32'h0000_0000, 32'h8000_0000, 32'h8000_0000);
        send_request(32'h0000_ffff, 32'h0000_0000, 32'h0001_0000);
        send_request(32'h7fff_8000, 32'h0000_0000, 32'h8000_0001);
        send_request(32'h8000_0000, 32'h0000_0000, 32'h8000_0001);
        send_request(32'h0000_0002, 32'hffff_ffff, 32'h0000_0003);
        send_request(32'h0000_fffe, 32'hffff_0000, 32'h0000_ffff);
        send_request(32'h8000_0000, 32'h0000_ffff, 32'hffff_0001);
        send_request(32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaab);
        send_request(32'h0000_0000, 32'hffff_ffff, 32'h0000_0002);
        drain_requests();

        send_random_requests(ITEMS_PER_PHASE);
        drain_requests();

        send_gap_pct  = 78;
        rsp_stall_pct = 0;
        send_random_requests(ITEMS_PER_PHASE);

        send_gap_pct  = 0;
        rsp_stall_pct = 78;
        send_random_requests(ITEMS_PER_PHASE);
        drain_requests();

        send_gap_pct  = 9;
        rsp_stall_pct = 9;
        send_random_requests(ITEMS_PER_PHASE);

        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
